[rtl/integer_sequence_queue_top_macros.svh]
// Assertion macros for the integer sequence queue.
// Included by integer_sequence_queue_top.sv; no other dependencies.
`ifndef INTEGER_SEQUENCE_QUEUE_TOP_MACROS_SVH
`define INTEGER_SEQUENCE_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/isq_pkg.sv]
// Shared types and constants for the integer sequence queue.
// No dependencies; used by integer_sequence_queue_top.sv.
`timescale 1ns / 1ps
`default_nettype none

package isq_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = (CW > 5) ? CW : 5;

    // operation codes
    localparam logic [2:0] K_APPEND      = 3'd0;
    localparam logic [2:0] K_REMOVE_HEAD = 3'd1;
    localparam logic [2:0] K_READ_HEAD   = 3'd2;
    localparam logic [2:0] K_LENGTH      = 3'd3;
    localparam logic [2:0] K_READ_AT     = 3'd4;
    localparam logic [2:0] K_DELETE_AT   = 3'd5;
    localparam logic [2:0] K_FIND        = 3'd6;
    localparam logic [2:0] K_CLEAR       = 3'd7;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NOPOS    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [4:0]         position;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] data;
        logic [4:0]         found_position;
        logic [4:0]         length;
    } t_result;

endpackage

`default_nettype wire

[rtl/isq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module isq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/integer_sequence_queue_top.sv]
// Integer sequence queue: ordered store of signed words with indexed access and search.
// Depends on isq_pkg, isq_ram and integer_sequence_queue_top_macros.svh.
//
// Usage: drive i_cmd and raise start; the command is taken at a clock edge where
// start is high and busy is low. Every command gives exactly one transaction on
// o_result, valid for one cycle while o_done is high; the receiver cannot stall it.
// How each command completes after the accepting edge:
//   append, length, clear, and any command that fails its checks: o_done in the
//   next cycle, and busy stays low, so such commands can issue every cycle.
//   read head, read at: through the S_READ state (one registered RAM read).
//   find: walks the entries from the head and stops at the first match, or at the
//   last entry when there is no match.
//   remove head, delete at: no walk for the last entry, else each later entry moves
//   down one slot, one entry moved per cycle through the single RAM port pair.
// The entry RAM is walked one word a cycle by one shared compare/index unit.
// busy is high while a read or a walk runs.
// Reset (synchronous, active low) empties the queue; RAM contents are not cleared
// and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_sequence_queue_top_macros.svh"

module integer_sequence_queue_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire isq_pkg::t_cmd    i_cmd,
    output logic                  o_done,
    output isq_pkg::t_result      o_result
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_FIND  = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    logic [1:0]                r_state, n_state;
    isq_pkg::t_cmd             r_cmd, n_cmd;
    logic [isq_pkg::CW-1:0]    r_count, n_count;
    logic [isq_pkg::AW-1:0]    r_idx, n_idx;
    isq_pkg::t_result          r_res, n_res;
    logic                      r_done, n_done;

    logic                      w_accept;
    logic                      w_empty;
    logic                      w_full;
    logic                      w_pos_bad;
    logic [isq_pkg::AW-1:0]    w_pos_idx;
    logic [isq_pkg::AW-1:0]    w_op_idx;
    logic [isq_pkg::AW-1:0]    w_last;
    logic [isq_pkg::CW-1:0]    w_idx_p1;
    logic [isq_pkg::CW-1:0]    w_idx_p2;

    logic                      w_we;
    logic [isq_pkg::AW-1:0]    w_waddr;
    logic [31:0]               w_wdata;
    logic [isq_pkg::AW-1:0]    w_raddr;
    logic [31:0]               w_rdata;

    isq_ram #(
        .WIDTH (32),
        .DEPTH (isq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign o_done   = r_done;
    assign o_result = r_res;

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count >= isq_pkg::CW'(isq_pkg::DEPTH));
    assign w_pos_bad = (i_cmd.position == 5'd0)
                    || (isq_pkg::PW'(i_cmd.position) > isq_pkg::PW'(r_count));
    assign w_pos_idx = isq_pkg::AW'(isq_pkg::PW'(i_cmd.position) - isq_pkg::PW'(1));
    assign w_last    = isq_pkg::AW'(r_count - isq_pkg::CW'(1));
    assign w_idx_p1  = isq_pkg::CW'(r_idx) + isq_pkg::CW'(1);
    assign w_idx_p2  = isq_pkg::CW'(r_idx) + isq_pkg::CW'(2);

    // head operations use slot 0, positional ones the slot of the given 1-based position
    assign w_op_idx  = ((i_cmd.kind == isq_pkg::K_READ_AT) || (i_cmd.kind == isq_pkg::K_DELETE_AT))
                     ? w_pos_idx : '0;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_count = r_count;
        n_idx   = r_idx;
        n_res   = r_res;
        n_done  = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_rdata;
        w_raddr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd  = i_cmd;
                    n_done = 1'b1;
                    n_res.status         = isq_pkg::ST_OK;
                    n_res.data           = '0;
                    n_res.found_position = '0;
                    case (i_cmd.kind)
                        isq_pkg::K_APPEND: begin
                            if (w_full) begin
                                n_res.status = isq_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = isq_pkg::AW'(r_count);
                                w_wdata = i_cmd.value;
                                n_count = r_count + isq_pkg::CW'(1);
                            end
                        end
                        isq_pkg::K_REMOVE_HEAD, isq_pkg::K_DELETE_AT: begin
                            if (w_empty) begin
                                n_res.status = isq_pkg::ST_EMPTY;
                            end else if ((i_cmd.kind == isq_pkg::K_DELETE_AT) && w_pos_bad) begin
                                n_res.status = isq_pkg::ST_NOPOS;
                            end else if (w_op_idx == w_last) begin
                                n_count = r_count - isq_pkg::CW'(1);
                            end else begin
                                // close up: fetch the entry after the gap
                                w_raddr = w_op_idx + isq_pkg::AW'(1);
                                n_idx   = w_op_idx;
                                n_state = S_SHIFT;
                                n_done  = 1'b0;
                            end
                        end
                        isq_pkg::K_READ_HEAD, isq_pkg::K_READ_AT: begin
                            if (w_empty) begin
                                n_res.status = isq_pkg::ST_EMPTY;
                            end else if ((i_cmd.kind == isq_pkg::K_READ_AT) && w_pos_bad) begin
                                n_res.status = isq_pkg::ST_NOPOS;
                            end else begin
                                w_raddr = w_op_idx;
                                n_state = S_READ;
                                n_done  = 1'b0;
                            end
                        end
                        isq_pkg::K_FIND: begin
                            if (w_empty) begin
                                n_res.status = isq_pkg::ST_NOTFOUND;
                            end else begin
                                w_raddr = '0;
                                n_idx   = '0;
                                n_state = S_FIND;
                                n_done  = 1'b0;
                            end
                        end
                        isq_pkg::K_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_res.length = 5'(n_count);
                end
            end
            S_READ: begin
                n_res.status         = isq_pkg::ST_OK;
                n_res.data           = w_rdata;
                n_res.found_position = '0;
                n_res.length         = 5'(r_count);
                n_done               = 1'b1;
                n_state              = S_IDLE;
            end
            S_FIND: begin
                n_res.data   = '0;
                n_res.length = 5'(r_count);
                if (w_rdata == r_cmd.value) begin
                    n_res.status         = isq_pkg::ST_OK;
                    n_res.found_position = 5'(w_idx_p1);
                    n_done               = 1'b1;
                    n_state              = S_IDLE;
                end else if (w_idx_p1 == r_count) begin
                    n_res.status         = isq_pkg::ST_NOTFOUND;
                    n_res.found_position = '0;
                    n_done               = 1'b1;
                    n_state              = S_IDLE;
                end else begin
                    w_raddr = r_idx + isq_pkg::AW'(1);
                    n_idx   = r_idx + isq_pkg::AW'(1);
                end
            end
            S_SHIFT: begin
                // move the fetched entry down one slot
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_rdata;
                if (w_idx_p2 == r_count) begin
                    n_count              = r_count - isq_pkg::CW'(1);
                    n_res.status         = isq_pkg::ST_OK;
                    n_res.data           = '0;
                    n_res.found_position = '0;
                    n_res.length         = 5'(r_count - isq_pkg::CW'(1));
                    n_done               = 1'b1;
                    n_state              = S_IDLE;
                end else begin
                    w_raddr = r_idx + isq_pkg::AW'(2);
                    n_idx   = r_idx + isq_pkg::AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    `ISQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= isq_pkg::CW'(isq_pkg::DEPTH), "count exceeds depth")
    `ISQ_ASSERT_NOW(a_len_match, i_clk, i_rst_n, o_done, o_result.length == 5'(r_count), "reported length differs from count")
    `ISQ_ASSERT_NOW(a_no_done_busy, i_clk, i_rst_n, busy, !o_done, "transaction reported during walk")
    `ISQ_ASSERT_NEXT(a_append_grow, i_clk, i_rst_n, w_accept && (i_cmd.kind == isq_pkg::K_APPEND) && !w_full, r_count == $past(r_count) + isq_pkg::CW'(1), "append did not grow queue")

endmodule

`default_nettype wire
